// ===== rtl/core/csd_pkg.sv =====
// shared types and constants for the strided dma register block
// no dependencies
package csd_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	localparam logic [3:0] REG_LOCAL  = 4'd0;
	localparam logic [3:0] REG_MAIN   = 4'd1;
	localparam logic [3:0] REG_RDLEN  = 4'd2;
	localparam logic [3:0] REG_WRLEN  = 4'd3;
	localparam logic [3:0] REG_STATUS = 4'd4;
	localparam logic [3:0] REG_SEMA   = 4'd7;
	localparam logic [3:0] REG_PC     = 4'd8;

	localparam int IN_W  = 40;
	localparam int OUT_W = 80;
	localparam int QUEUE_DEPTH = 2;

	// classified item handed from front to back
	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  reg_index;
		logic [31:0] wr_data;
	} item_t;

	// result fields, last travels separately
	typedef struct packed {
		logic        rejected;
		logic        intr_clear;
		logic        intr_raise;
		logic        main_in_range;
		logic [26:0] main_addr;
		logic [12:0] local_addr;
		logic        to_main;
		logic        xfer_valid;
		logic        busy_res;
		logic [31:0] rd_data;
	} result_t;

endpackage

// ===== rtl/core/csd_front.sv =====
// front end: accepts items, classifies the command, queues them for the back end
// depends on csd_pkg
module csd_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [csd_pkg::IN_W-1:0]       s_tdata,
	output logic                           q_valid,
	input  logic                           q_ready,
	output csd_pkg::item_t                 q_item
);

	csd_pkg::item_t entry_q [csd_pkg::QUEUE_DEPTH];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;
	logic           push, pop;
	csd_pkg::item_t in_item;

	// classify the incoming item
	always_comb begin
		in_item.cmd       = csd_pkg::cmd_t'(s_tdata[1:0]);
		in_item.reg_index = s_tdata[5:2];
		in_item.wr_data   = s_tdata[37:6];
	end

	assign s_tready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== rtl/core/csd_back.sv =====
// back end: register file, dma sequencer and output register
// depends on csd_pkg
module csd_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  csd_pkg::item_t            q_item,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [csd_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tlast
);

	logic [31:0] local_reg_q, main_reg_q, rdlen_q, wrlen_q;
	logic [14:0] status_q;
	logic        sema_q;
	logic [11:0] pc_q;
	logic        active_q, dir_q;
	logic [8:0]  rows_left_q;
	logic [12:0] bytes_left_q, row_bytes_q;
	logic [11:0] row_skip_q;
	logic [26:0] main_ptr_q;
	logic [11:0] local_ptr_q;

	logic [31:0] local_reg_d, main_reg_d, rdlen_d, wrlen_d;
	logic [14:0] status_d;
	logic        sema_d;
	logic [11:0] pc_d;
	logic        active_d, dir_d;
	logic [8:0]  rows_left_d;
	logic [12:0] bytes_left_d, row_bytes_d;
	logic [11:0] row_skip_d;
	logic [26:0] main_ptr_d;
	logic [11:0] local_ptr_d;

	csd_pkg::result_t res_d, res_q;
	logic             last_d, last_q, out_valid_q, go;
	logic [31:0]      v;
	logic [8:0]       st_rows;
	logic [12:0]      st_bytes;
	logic [11:0]      st_skip;
	logic [25:0]      st_main;
	logic [20:0]      skip_prod;
	logic [26:0]      main_next;
	logic             finish;

	assign q_ready = !out_valid_q || m_tready;
	assign go      = q_valid && q_ready;
	assign v       = q_item.wr_data;

	// length register decode for a starting copy
	assign st_skip   = {v[31:23], 3'b000};
	assign st_rows   = {1'b0, v[19:12]} + 9'd1;
	assign st_bytes  = ({1'b0, v[11:0]} + 13'd7) & 13'h1ff8;
	assign st_main   = main_reg_q[25:0] & 26'h3fffff8;
	assign skip_prod = {12'd0, st_rows} * {9'd0, st_skip};

	// next state and result
	always_comb begin
		local_reg_d = local_reg_q; main_reg_d = main_reg_q;
		rdlen_d = rdlen_q; wrlen_d = wrlen_q;
		status_d = status_q; sema_d = sema_q; pc_d = pc_q;
		active_d = active_q; dir_d = dir_q; rows_left_d = rows_left_q;
		bytes_left_d = bytes_left_q; row_bytes_d = row_bytes_q;
		row_skip_d = row_skip_q; main_ptr_d = main_ptr_q; local_ptr_d = local_ptr_q;
		res_d = '0; last_d = 1'b0; finish = 1'b0; main_next = main_ptr_q;
		case (q_item.cmd)
			csd_pkg::CMD_READ: begin
				case (q_item.reg_index)
					csd_pkg::REG_LOCAL:  res_d.rd_data = local_reg_q;
					csd_pkg::REG_MAIN:   res_d.rd_data = main_reg_q;
					csd_pkg::REG_RDLEN:  res_d.rd_data = rdlen_q;
					csd_pkg::REG_WRLEN:  res_d.rd_data = wrlen_q;
					csd_pkg::REG_STATUS: res_d.rd_data = {17'd0, status_q};
					csd_pkg::REG_SEMA: begin
						res_d.rd_data = {31'd0, sema_q};
						sema_d = 1'b1;
					end
					csd_pkg::REG_PC:     res_d.rd_data = {20'd0, pc_q};
					default:             res_d.rd_data = '0;
				endcase
			end
			csd_pkg::CMD_WRITE: begin
				if (active_q) begin
					res_d.rejected = 1'b1;
				end else begin
					case (q_item.reg_index)
						csd_pkg::REG_LOCAL: local_reg_d = v;
						csd_pkg::REG_MAIN:  main_reg_d = v;
						csd_pkg::REG_RDLEN, csd_pkg::REG_WRLEN: begin
							dir_d = (q_item.reg_index == csd_pkg::REG_WRLEN);
							if (dir_d) wrlen_d = v;
							else       rdlen_d = v;
							row_skip_d   = st_skip;
							rows_left_d  = st_rows;
							row_bytes_d  = st_bytes;
							local_ptr_d  = {local_reg_q[11:3], 3'b000};
							bytes_left_d = st_bytes;
							if (st_bytes == 13'd0) begin
								main_next = {1'b0, st_main} + {6'd0, skip_prod};
								finish = 1'b1;
							end else begin
								main_ptr_d = {1'b0, st_main};
								active_d = 1'b1;
							end
						end
						csd_pkg::REG_STATUS: begin
							if (v[1:0] == 2'b01) status_d[0] = 1'b0;
							else if (v[1:0] == 2'b10) status_d[0] = 1'b1;
							if (v[2]) status_d[1] = 1'b0;
							res_d.intr_clear = (v[4:3] == 2'b01);
							res_d.intr_raise = (v[4:3] == 2'b10);
							for (int k = 0; k < 10; k++) begin
								if (v[5+2*k +: 2] == 2'b01) status_d[5+k] = 1'b0;
								else if (v[5+2*k +: 2] == 2'b10) status_d[5+k] = 1'b1;
							end
						end
						csd_pkg::REG_SEMA: sema_d = 1'b0;
						csd_pkg::REG_PC:   pc_d = v[11:0] & 12'hffc;
						default: ;
					endcase
				end
			end
			csd_pkg::CMD_TICK: begin
				if (active_q) begin
					res_d.xfer_valid    = 1'b1;
					res_d.to_main       = dir_q;
					res_d.local_addr    = {local_reg_q[12], local_ptr_q};
					res_d.main_addr     = main_ptr_q;
					res_d.main_in_range = (main_ptr_q[26:23] == 4'd0);
					local_ptr_d  = local_ptr_q + 12'd1;
					main_next    = main_ptr_q + 27'd1;
					local_reg_d  = {local_reg_q[31:12], local_reg_q[11:0] + 12'd1};
					bytes_left_d = bytes_left_q - 13'd1;
					main_ptr_d   = main_next;
					if (bytes_left_q == 13'd1) begin
						main_next   = main_ptr_q + 27'd1 + {15'd0, row_skip_q};
						main_ptr_d  = main_next;
						rows_left_d = rows_left_q - 9'd1;
						if (rows_left_q == 9'd1) begin
							last_d = 1'b1;
							finish = 1'b1;
						end else begin
							bytes_left_d = row_bytes_q;
						end
					end
				end
			end
			default: ;
		endcase
		// end of transfer bookkeeping
		if (finish) begin
			main_ptr_d  = main_next;
			main_reg_d  = {5'd0, main_next};
			local_reg_d = {local_reg_d[31:3], 3'b000};
			if (dir_d) wrlen_d = {wrlen_d[31:20], 20'h00ff8};
			else       rdlen_d = {rdlen_d[31:20], 20'h00ff8};
			active_d = 1'b0;
		end
		res_d.busy_res = active_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_reg_q <= '0; main_reg_q <= '0; rdlen_q <= '0; wrlen_q <= '0;
			status_q <= 15'd1; sema_q <= 1'b0; pc_q <= '0;
			active_q <= 1'b0; dir_q <= 1'b0; rows_left_q <= '0;
			bytes_left_q <= '0; row_bytes_q <= '0; row_skip_q <= '0;
			main_ptr_q <= '0; local_ptr_q <= '0;
		end else if (go) begin
			local_reg_q <= local_reg_d; main_reg_q <= main_reg_d;
			rdlen_q <= rdlen_d; wrlen_q <= wrlen_d;
			status_q <= status_d; sema_q <= sema_d; pc_q <= pc_d;
			active_q <= active_d; dir_q <= dir_d; rows_left_q <= rows_left_d;
			bytes_left_q <= bytes_left_d; row_bytes_q <= row_bytes_d;
			row_skip_q <= row_skip_d; main_ptr_q <= main_ptr_d; local_ptr_q <= local_ptr_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_ready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q  <= res_d;
			last_q <= last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q};
	assign m_tlast  = last_q;

	// sequencer sanity
	a_rows: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> rows_left_q != 9'd0) else $error("active with no rows left");
	a_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> bytes_left_q != 13'd0 && row_bytes_q != 13'd0)
		else $error("active with empty row");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> res_q.busy_res == active_q) else $error("busy flag disagrees with state");

endmodule

// ===== rtl/core/coprocessor_regs_strided_dma.sv =====
// Register block of a signal coprocessor with a strided dma engine.
// Slave channel carries commands: read, write or tick, plus register index
// and write data. Master channel returns exactly one result per command:
// read data, busy flag, rejected flag, interrupt pulses, and for a tick the
// byte transfer (direction, local and main address, range flag); tlast
// marks the final byte of a copy.
// A write to a length register starts a copy of rows rounded up to 8
// bytes; each later tick moves one byte. Memories sit outside the block.
// Throughput: one command per cycle while the master side is not stalled.
// A command is registered first in the front queue, then its result in the
// back end's output register. The two-entry queue lets the slave side
// keep taking items while the receiver stalls; when queue and output
// register are full, s_tready drops until the master side drains.
// Reset clears all registers and counters, sets the halt status bit and
// empties the queue and the output register; no clearing pass is needed.
// depends on csd_pkg, csd_front, csd_back
module coprocessor_regs_strided_dma (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cmd[1:0], reg_index[5:2], wr_data[37:6], zero[39:38]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// rd_data[31:0], busy_res[32], xfer_valid[33], to_main[34], local_addr[47:35],
	// main_addr[74:48], main_in_range[75], intr_raise[76], intr_clear[77],
	// rejected[78], zero[79]
	output logic [79:0] m_tdata,
	output logic        m_tlast
);

	logic           q_valid, q_ready;
	csd_pkg::item_t q_item;

	csd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	csd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

endmodule

// ===== tb/sv/csd_checker.sv =====
// checker for the strided dma register block: watches both streams,
// predicts each result from the commands taken in and compares them in order
// depends on csd_pkg
`timescale 1ns / 1ps

module csd_checker
	import csd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,
	input  logic        m_tlast,
	output int          errors,
	output int          pending
);

	localparam logic [31:0] LOCAL_BYTES = 32'd4096;
	localparam logic [31:0] MAIN_LIMIT  = 32'd8388608;
	localparam logic [31:0] MAIN_MASK   = 32'h7ff_ffff;

	typedef struct {
		logic [79:0] data;
		logic        lst;
	} dma_result_t;

	dma_result_t expected_results[$];

	// register file copy
	logic [31:0] local_reg, main_reg, rdlen_reg, wrlen_reg, status, sema, pc;
	logic [31:0] active, dir, rows, bytes_rem, row_len, skip, mptr, lptr;

	assign pending = expected_results.size();

	function automatic void end_copy();
		main_reg = mptr;
		local_reg &= ~32'd7;
		if (dir[0])
			wrlen_reg = (wrlen_reg & 32'hfff0_0000) | 32'hff8;
		else
			rdlen_reg = (rdlen_reg & 32'hfff0_0000) | 32'hff8;
		active = 0;
	endfunction

	function automatic void begin_copy(logic [31:0] len, logic d);
		dir = d;
		skip = (len >> 20) & 32'hff8;
		rows = ((len >> 12) & 32'hff) + 1;
		row_len = ((len & 32'hfff) + 7) & ~32'd7;
		mptr = main_reg & 32'h3ff_fff8;
		lptr = local_reg & (LOCAL_BYTES - 1) & ~32'd7;
		if (row_len == 0) begin
			mptr = (mptr + rows * skip) & MAIN_MASK;
			end_copy();
		end else begin
			bytes_rem = row_len;
			active = 1;
		end
	endfunction

	// work out the result of one command
	function automatic dma_result_t predict_dma(logic [39:0] d);
		dma_result_t r;
		result_t res;
		cmd_t c;
		logic [3:0] idx;
		logic [31:0] v;
		logic [1:0] pair;
		res = '0;
		r.lst = 0;
		c = cmd_t'(d[1:0]);
		idx = d[5:2];
		v = d[37:6];
		if (c == CMD_READ) begin
			case (idx)
				REG_LOCAL:  res.rd_data = local_reg;
				REG_MAIN:   res.rd_data = main_reg;
				REG_RDLEN:  res.rd_data = rdlen_reg;
				REG_WRLEN:  res.rd_data = wrlen_reg;
				REG_STATUS: res.rd_data = status;
				REG_SEMA: begin
					res.rd_data = sema;
					sema = 1;
				end
				REG_PC:     res.rd_data = pc;
				default:    res.rd_data = 0;
			endcase
		end else if (c == CMD_WRITE) begin
			if (active) begin
				res.rejected = 1;
			end else begin
				case (idx)
					REG_LOCAL: local_reg = v;
					REG_MAIN:  main_reg = v;
					REG_RDLEN: begin
						rdlen_reg = v;
						begin_copy(v, 0);
					end
					REG_WRLEN: begin
						wrlen_reg = v;
						begin_copy(v, 1);
					end
					REG_STATUS: begin
						if (v[1:0] == 2'b01) status[0] = 0;
						else if (v[1:0] == 2'b10) status[0] = 1;
						if (v[2]) status[1] = 0;
						if (v[4:3] == 2'b01) res.intr_clear = 1;
						else if (v[4:3] == 2'b10) res.intr_raise = 1;
						for (int k = 0; k < 10; k++) begin
							pair = v[5+2*k +: 2];
							if (pair == 2'b01) status[5+k] = 0;
							else if (pair == 2'b10) status[5+k] = 1;
						end
						status &= 32'h7fff;
					end
					REG_SEMA: sema = 0;
					REG_PC:   pc = v & 32'hffc;
					default: ;
				endcase
			end
		end else if (c == CMD_TICK && active) begin
			res.xfer_valid = 1;
			res.to_main = dir[0];
			res.local_addr = {local_reg[12], lptr[11:0]};
			res.main_addr = mptr[26:0];
			res.main_in_range = mptr < MAIN_LIMIT;
			lptr = (lptr + 1) & (LOCAL_BYTES - 1);
			mptr = (mptr + 1) & MAIN_MASK;
			local_reg = {local_reg[31:12], local_reg[11:0] + 12'd1};
			bytes_rem--;
			if (bytes_rem == 0) begin
				mptr = (mptr + skip) & MAIN_MASK;
				rows--;
				if (rows == 0) begin
					r.lst = 1;
					end_copy();
				end else begin
					bytes_rem = row_len;
				end
			end
		end
		res.busy_res = active[0];
		r.data = res;
		return r;
	endfunction

	// predict on input, compare on output
	always @(posedge clk or negedge arst_n) begin
		dma_result_t want;
		if (!arst_n) begin
			expected_results.delete();
			errors <= 0;
			local_reg = 0; main_reg = 0; rdlen_reg = 0; wrlen_reg = 0;
			status = 1; sema = 0; pc = 0;
			active = 0; dir = 0; rows = 0; bytes_rem = 0; row_len = 0;
			skip = 0; mptr = 0; lptr = 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_dma(s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_tdata);
					errors <= errors + 1;
				end else begin
					want = expected_results.pop_front();
					if (want.data !== m_tdata || want.lst !== m_tlast) begin
						$display("%0t: expected %h last %b, actual %h last %b",
							$time, want.data, want.lst, m_tdata, m_tlast);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb_coprocessor_regs_strided_dma.sv =====
// top of the strided dma register block testbench: clock, reset, command
// stimulus with random gaps and stalls, verdict
// depends on csd_pkg, csd_checker and the block
`timescale 1ns / 1ps

module tb_coprocessor_regs_strided_dma;
	import csd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tlast;
	int          errors;
	int          pending;
	int          n_sent;    // items accepted so far
	logic        calm;      // no idling in the last part
	logic        hold_long; // long receiver hold-off

	coprocessor_regs_strided_dma dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	csd_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// send one command, with a random gap before it
	task automatic send_cmd(cmd_t c, logic [3:0] idx, logic [31:0] v);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {2'b00, v, idx, c};
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	// whole copy: addresses, length, then ticks until done plus some extra
	task automatic run_copy(logic [31:0] loc, logic [31:0] mn, logic [31:0] len, bit wr);
		int n;
		n = ((((len & 32'hfff) + 7) & ~32'd7)) * (((len >> 12) & 32'hff) + 1);
		send_cmd(CMD_WRITE, REG_LOCAL, loc);
		send_cmd(CMD_WRITE, REG_MAIN, mn);
		send_cmd(CMD_WRITE, wr ? REG_WRLEN : REG_RDLEN, len);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_cmd(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom);
			send_cmd(CMD_TICK, 4'($urandom_range(0, 15)), $urandom);
		end
		send_cmd(CMD_TICK, REG_LOCAL, 32'd0);
		send_cmd(CMD_READ, REG_LOCAL, 0);
		send_cmd(CMD_READ, REG_MAIN, 0);
		send_cmd(CMD_READ, wr ? REG_WRLEN : REG_RDLEN, 0);
	endtask

	// random small length: few rows, short rows, random skip
	function automatic logic [31:0] pick_len();
		return {12'($urandom), 8'($urandom_range(0, 2)), 12'($urandom_range(0, 20))};
	endfunction

	// receiver stalls
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				m_tready <= 0;
				repeat (60) @(posedge clk);
				m_tready <= 1;
				while (hold_long) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 19);
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end else begin
				m_tready <= 1;
				@(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		calm = 0;
		hold_long = 0;
		n_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every register, status pairs, semaphore, pc, empty copy
		send_cmd(CMD_READ, REG_STATUS, 0);
		send_cmd(CMD_READ, 4'd15, 0);
		send_cmd(CMD_TICK, REG_LOCAL, 0);
		send_cmd(CMD_NOP, 4'd15, 32'hffff_ffff);
		send_cmd(CMD_WRITE, REG_STATUS, 32'h0155_5555);
		send_cmd(CMD_READ, REG_STATUS, 0);
		send_cmd(CMD_WRITE, REG_STATUS, 32'h01aa_aaaa);
		send_cmd(CMD_READ, REG_STATUS, 0);
		send_cmd(CMD_WRITE, REG_STATUS, 32'hffff_ffff);
		send_cmd(CMD_WRITE, REG_STATUS, 32'h0000_0008);
		send_cmd(CMD_READ, REG_SEMA, 0);
		send_cmd(CMD_READ, REG_SEMA, 0);
		send_cmd(CMD_WRITE, REG_SEMA, 32'hffff_ffff);
		send_cmd(CMD_READ, REG_SEMA, 0);
		send_cmd(CMD_WRITE, REG_PC, 32'hffff_ffff);
		send_cmd(CMD_READ, REG_PC, 0);
		send_cmd(CMD_WRITE, 4'd5, 32'hffff_ffff);
		send_cmd(CMD_READ, 4'd6, 0);
		// zero row length finishes at once with skips applied
		send_cmd(CMD_WRITE, REG_MAIN, 32'hffff_ffff);
		send_cmd(CMD_WRITE, REG_RDLEN, 32'hfffff000);
		send_cmd(CMD_READ, REG_MAIN, 0);
		// local wrap, memory select, main above the limit, busy rejection
		run_copy(32'hffff_fffa, 32'h00ff_fff0, 32'h0080_0009, 1'b1);
		run_copy(32'h0000_0000, 32'h007f_fffc, 32'h0000_0001, 1'b0);

		// back-pressure: long hold-off while commands keep coming
		hold_long = 1;
		for (int i = 0; i < 12; i++)
			send_cmd(CMD_READ, REG_STATUS, 0);
		hold_long = 0;

		// random copies with random registers and noise between
		while (n_sent < 1350) begin
			if (n_sent > 1100) calm = 1;
			if ($urandom_range(0, 3) != 0) begin
				run_copy($urandom, $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 32'h7f_ffff)),
					pick_len(), 1'($urandom_range(0, 1)));
			end else begin
				send_cmd(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom);
			end
		end
		s_tvalid <= 0;
		calm = 1;

		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
